### hw/rtl/ptc_pkg.sv
// Shared types and helpers for the pressure/temperature compensation core.
// Item, result and calibration structs; sign extension helpers.
// No dependencies.
package ptc_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    typedef struct packed {
        logic [19:0] adc_temperature;
        logic [19:0] adc_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [23:0]        pressure_pa;
        logic               divisor_zero;
    } t_res_item;

    typedef struct packed {
        logic [31:0] d1;
        logic [31:0] d2;
        logic [20:0] pc;
    } t_fitem;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    localparam logic [1:0] RegTempCal  = 2'd0;
    localparam logic [1:0] RegPressA   = 2'd1;
    localparam logic [1:0] RegPressB   = 2'd2;
    localparam logic [1:0] RegPressP9  = 2'd3;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

### hw/rtl/ptc_front.sv
// Front stage: latch samples; form temperature deltas, pressure term.
// Depends on ptc_pkg.
module ptc_front import ptc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_in,
    input  logic [15:0] i_t1,
    output logic     o_fq_push,
    output t_fitem   o_fq,
    input  logic     i_fq_full
);
    logic   r_valid;
    t_fitem r_item;
    logic   accept;

    assign o_full    = r_valid && i_fq_full;
    assign accept    = i_push && !o_full;
    assign o_fq_push = r_valid && !i_fq_full;
    assign o_fq      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_fq_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.d1 <= {15'd0, i_in.adc_temperature[19:3]} - {15'd0, i_t1, 1'b0};
            r_item.d2 <= {16'd0, i_in.adc_temperature[19:4]} - {16'd0, i_t1};
            r_item.pc <= 21'h10_0000 - {1'b0, i_in.adc_pressure};
        end
    end
endmodule

### hw/rtl/ptc_fifo.sv
// Short queue between front and back stages.
// Depends on ptc_pkg.
module ptc_fifo import ptc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_fitem i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_fitem o_data
);
    t_fitem             r_mem [FifoDepth];
    logic [FifoAw-1:0]  r_wp;
    logic [FifoAw-1:0]  r_rp;
    logic [FifoAw:0]    r_cnt;

    assign o_full  = (r_cnt == (FifoAw+1)'(FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

### hw/rtl/ptc_back.sv
// Back stage: sequencer over one shared 32x32 multiplier and a radix-2 divider.
// Depends on ptc_pkg.
module ptc_back import ptc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cal      i_cal,
    input  logic      i_fq_valid,
    input  t_fitem    i_fq,
    output logic      o_fq_pop,
    output logic      o_res_valid,
    output t_res_item o_res,
    input  logic      i_res_ready
);
    typedef enum logic [17:0] {
        B_IDLE = 18'h00001, B_M1  = 18'h00002, B_M2  = 18'h00004,
        B_M3   = 18'h00008, B_TF  = 18'h00010, B_M5  = 18'h00020,
        B_M6   = 18'h00040, B_M7  = 18'h00080, B_M8  = 18'h00100,
        B_M9   = 18'h00200, B_M10 = 18'h00400, B_M11 = 18'h00800,
        B_DIV  = 18'h01000, B_QFIX = 18'h02000, B_M12 = 18'h04000,
        B_M13  = 18'h08000, B_M14 = 18'h10000, B_OUT = 18'h20000
    } t_bstate;

    t_bstate     r_state;
    logic [1:0]  r_ph;
    logic [63:0] r_ma, r_mb, r_acc;
    logic [31:0] r_d2, r_tf, r_tc;
    logic [20:0] r_pc;
    logic [63:0] r_v1, r_a, r_v2, r_t, r_div, r_dabs, r_quo, r_rem, r_q, r_w;
    logic        r_neg, r_zero;
    logic [5:0]  r_cnt;
    logic [23:0] r_pa;

    logic [31:0] mx, my;
    logic [63:0] mp;
    logic        is_mul;
    logic [31:0] tf_n;
    logic [63:0] v1_n, t_n, dvd_n, q_n, div_n, p_n;
    logic [64:0] rem_sh, rem_diff;

    assign mx = (r_ph == 2'd2) ? r_ma[63:32] : r_ma[31:0];
    assign my = (r_ph == 2'd1) ? r_mb[63:32] : r_mb[31:0];
    assign mp = mx * my;

    assign is_mul = (r_state == B_M1) || (r_state == B_M2) || (r_state == B_M3)
        || (r_state == B_M5) || (r_state == B_M6) || (r_state == B_M7)
        || (r_state == B_M8) || (r_state == B_M9) || (r_state == B_M10)
        || (r_state == B_M11) || (r_state == B_M12) || (r_state == B_M13)
        || (r_state == B_M14);

    assign tf_n  = r_tf + 32'($signed(r_acc[31:0]) >>> 14);
    assign v1_n  = sx32(r_tf) - 64'd128000;
    assign t_n   = r_t + {r_acc[51:0], 12'd0} + 64'h0000_8000_0000_0000;
    assign div_n = 64'($signed(r_acc) >>> 33);
    assign dvd_n = {12'd0, r_pc, 31'd0} - r_v2;
    assign q_n   = r_neg ? (64'd0 - r_quo) : r_quo;
    assign p_n   = 64'($signed(r_q + r_w + 64'($signed(r_acc) >>> 19)) >>> 8)
                   + {{44{i_cal.p7[15]}}, i_cal.p7, 4'd0};

    assign rem_sh   = {r_rem, r_quo[63]};
    assign rem_diff = rem_sh - {1'b0, r_dabs};

    assign o_fq_pop    = (r_state == B_IDLE) && i_fq_valid;
    assign o_res_valid = (r_state == B_OUT);
    assign o_res.temperature_centi = r_tc;
    assign o_res.pressure_pa       = r_pa;
    assign o_res.divisor_zero      = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ph    <= '0;
            r_cnt   <= '0;
        end else begin
            if (is_mul) begin
                r_ph <= r_ph + 1'b1;
            end
            unique case (r_state)
                B_IDLE: if (i_fq_valid) r_state <= B_M1;
                B_M1:   if (r_ph == 2'd3) r_state <= B_M2;
                B_M2:   if (r_ph == 2'd3) r_state <= B_M3;
                B_M3:   if (r_ph == 2'd3) r_state <= B_TF;
                B_TF:   r_state <= B_M5;
                B_M5:   if (r_ph == 2'd3) r_state <= B_M6;
                B_M6:   if (r_ph == 2'd3) r_state <= B_M7;
                B_M7:   if (r_ph == 2'd3) r_state <= B_M8;
                B_M8:   if (r_ph == 2'd3) r_state <= B_M9;
                B_M9:   if (r_ph == 2'd3) r_state <= B_M10;
                B_M10:  if (r_ph == 2'd3) r_state <= (div_n == '0) ? B_OUT : B_M11;
                B_M11: begin
                    r_cnt <= '0;
                    if (r_ph == 2'd3) r_state <= B_DIV;
                end
                B_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd63) r_state <= B_QFIX;
                end
                B_QFIX: r_state <= B_M12;
                B_M12:  if (r_ph == 2'd3) r_state <= B_M13;
                B_M13:  if (r_ph == 2'd3) r_state <= B_M14;
                B_M14:  if (r_ph == 2'd3) r_state <= B_OUT;
                B_OUT:  if (i_res_ready) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_mul) begin
            if (r_ph == 2'd0) begin
                r_acc <= mp;
            end else if (r_ph != 2'd3) begin
                r_acc <= r_acc + {mp[31:0], 32'd0};
            end
        end
        unique case (r_state)
            B_IDLE: begin
                r_d2 <= i_fq.d2;
                r_pc <= i_fq.pc;
                r_ma <= sx32(i_fq.d1);
                r_mb <= sx16(i_cal.t2);
            end
            B_M1: if (r_ph == 2'd3) begin
                r_tf <= 32'($signed(r_acc[31:0]) >>> 11);
                r_ma <= sx32(r_d2);
                r_mb <= sx32(r_d2);
            end
            B_M2: if (r_ph == 2'd3) begin
                r_ma <= sx32(32'($signed(r_acc[31:0]) >>> 12));
                r_mb <= sx16(i_cal.t3);
            end
            B_M3: if (r_ph == 2'd3) begin
                r_tf <= tf_n;
            end
            B_TF: begin
                r_tc <= 32'($signed({r_tf[29:0], 2'd0} + r_tf + 32'd128) >>> 8);
                r_v1 <= v1_n;
                r_ma <= v1_n;
                r_mb <= v1_n;
            end
            B_M5: if (r_ph == 2'd3) begin
                r_a  <= r_acc;
                r_ma <= r_acc;
                r_mb <= sx16(i_cal.p6);
            end
            B_M6: if (r_ph == 2'd3) begin
                r_v2 <= r_acc + {{13{i_cal.p4[15]}}, i_cal.p4, 35'd0};
                r_ma <= r_v1;
                r_mb <= sx16(i_cal.p5);
            end
            B_M7: if (r_ph == 2'd3) begin
                r_v2 <= r_v2 + {r_acc[46:0], 17'd0};
                r_ma <= r_a;
                r_mb <= sx16(i_cal.p3);
            end
            B_M8: if (r_ph == 2'd3) begin
                r_t  <= 64'($signed(r_acc) >>> 8);
                r_ma <= r_v1;
                r_mb <= sx16(i_cal.p2);
            end
            B_M9: if (r_ph == 2'd3) begin
                r_ma <= t_n;
                r_mb <= {48'd0, i_cal.p1};
            end
            B_M10: if (r_ph == 2'd3) begin
                r_div  <= div_n;
                r_zero <= (div_n == '0);
                r_pa   <= '0;
                r_ma   <= dvd_n;
                r_mb   <= 64'd3125;
            end
            B_M11: if (r_ph == 2'd3) begin
                r_neg  <= r_acc[63] ^ r_div[63];
                r_quo  <= r_acc[63] ? (64'd0 - r_acc) : r_acc;
                r_dabs <= r_div[63] ? (64'd0 - r_div) : r_div;
                r_rem  <= '0;
            end
            B_DIV: begin
                if (!rem_diff[64]) begin
                    r_rem <= rem_diff[63:0];
                end else begin
                    r_rem <= rem_sh[63:0];
                end
                r_quo <= {r_quo[62:0], !rem_diff[64]};
            end
            B_QFIX: begin
                r_q  <= q_n;
                r_ma <= sx16(i_cal.p9);
                r_mb <= 64'($signed(q_n) >>> 13);
            end
            B_M12: if (r_ph == 2'd3) begin
                r_ma <= r_acc;
                r_mb <= 64'($signed(r_q) >>> 13);
            end
            B_M13: if (r_ph == 2'd3) begin
                r_w  <= 64'($signed(r_acc) >>> 25);
                r_ma <= sx16(i_cal.p8);
                r_mb <= r_q;
            end
            B_M14: if (r_ph == 2'd3) begin
                r_pa <= p_n[31:8];
            end
            B_OUT: ;
            default: ;
        endcase
    end

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (r_ph == 2'd0))
        else $error("multiplier phase not reset in idle");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_rem < r_dabs))
        else $error("divider remainder out of range");

    a_zero_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_M10) && (r_ph == 2'd3) && (div_n == '0))
        |=> ((r_state == B_OUT) && r_zero && (r_pa == '0)))
        else $error("zero divisor not flagged");
endmodule

### hw/rtl/pressure_temp_compensation_core.sv
// Top level of the pressure/temperature compensation core.
// Holds the APB calibration registers and result register; uses ptc_pkg,
// ptc_front, ptc_fifo and ptc_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  samples  | i_push / o_full    | i_in  (t_in_item)
//  results  | o_empty / i_pop    | o_res (t_res_item)
//  config   | psel/penable/...   | paddr, pwdata, prdata (64b)
//
// Each sample passes the back stage as 13 shared 64-bit multiplies on one
// 32x32 multiplier plus a restoring divider; a zero divisor skips the divide
// and the multiplies after it and goes straight to the result.
// Reset is synchronous; no clearing pass. Front stage and a 4-deep queue take
// new samples while the back stage works and while a result waits in o_res.
module pressure_temp_compensation_core import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_in,
    output logic        o_empty,
    input  logic        i_pop,
    output t_res_item   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_p9;
    t_cal        cal;

    logic      fq_push, fq_full, fq_pop, fq_valid;
    t_fitem    fq_in, fq_out;
    logic      res_valid, res_ready;
    t_res_item res;
    logic      r_ovalid;
    t_res_item r_ores;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_press_a  <= '0;
            r_press_b  <= '0;
            r_p9       <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:3])
                RegTempCal: r_temp_cal <= pwdata[47:0];
                RegPressA:  r_press_a  <= pwdata;
                RegPressB:  r_press_b  <= pwdata;
                RegPressP9: r_p9       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            RegTempCal: prdata = {16'd0, r_temp_cal};
            RegPressA:  prdata = r_press_a;
            RegPressB:  prdata = r_press_b;
            RegPressP9: prdata = {48'd0, r_p9};
            default:    prdata = '0;
        endcase
    end

    assign cal.t1 = r_temp_cal[15:0];
    assign cal.t2 = r_temp_cal[31:16];
    assign cal.t3 = r_temp_cal[47:32];
    assign cal.p1 = r_press_a[15:0];
    assign cal.p2 = r_press_a[31:16];
    assign cal.p3 = r_press_a[47:32];
    assign cal.p4 = r_press_a[63:48];
    assign cal.p5 = r_press_b[15:0];
    assign cal.p6 = r_press_b[31:16];
    assign cal.p7 = r_press_b[47:32];
    assign cal.p8 = r_press_b[63:48];
    assign cal.p9 = r_p9;

    ptc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_in      (i_in),
        .i_t1      (cal.t1),
        .o_fq_push (fq_push),
        .o_fq      (fq_in),
        .i_fq_full (fq_full)
    );

    ptc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_in),
        .o_full  (fq_full),
        .i_pop   (fq_pop),
        .o_valid (fq_valid),
        .o_data  (fq_out)
    );

    ptc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cal       (cal),
        .i_fq_valid  (fq_valid),
        .i_fq        (fq_out),
        .o_fq_pop    (fq_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_ovalid || i_pop;
    assign o_empty   = !r_ovalid;
    assign o_res     = r_ores;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_ores <= res;
        end
    end
endmodule

### verif/ptc_checker.sv
// Checker for the pressure/temperature compensation core: mirrors the
// calibration writes, predicts each result and compares it field by field.
// Depends on ptc_pkg for the item and result types and register indices.
module ptc_checker import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_item    i_in,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_res_item   i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [47:0] temp_cal_q;
    logic [63:0] press_a_q;
    logic [63:0] press_b_q;
    logic [15:0] press_p9_q;
    t_res_item   expected_q[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    function automatic logic signed [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_res_item compensate(input t_in_item s);
        logic signed [31:0] t1, t2, t3, d1, d2, v1t, v2t, tf, tc;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, num, ps, w1, w2;
        logic [63:0]        an, ad, q;
        t_res_item          r;
        t1  = {16'd0, temp_cal_q[15:0]};
        t2  = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
        t3  = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
        d1  = {15'd0, s.adc_temperature[19:3]} - (t1 <<< 1);
        v1t = (d1 * t2) >>> 11;
        d2  = {16'd0, s.adc_temperature[19:4]} - t1;
        v2t = (((d2 * d2) >>> 12) * t3) >>> 14;
        tf  = v1t + v2t;
        tc  = (tf * 32'sd5 + 32'sd128) >>> 8;

        p1 = {48'd0, press_a_q[15:0]};
        p2 = sext16(press_a_q[31:16]);
        p3 = sext16(press_a_q[47:32]);
        p4 = sext16(press_a_q[63:48]);
        p5 = sext16(press_b_q[15:0]);
        p6 = sext16(press_b_q[31:16]);
        p7 = sext16(press_b_q[47:32]);
        p8 = sext16(press_b_q[63:48]);
        p9 = sext16(press_p9_q);

        v1 = {{32{tf[31]}}, tf} - 64'sd128000;
        v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = ((64'sd1 <<< 47) + v1) * p1;
        v1 = v1 >>> 33;

        r.temperature_centi = tc;
        if (v1 == 0) begin
            r.pressure_pa  = '0;
            r.divisor_zero = 1'b1;
        end else begin
            p   = 64'sd1048576 - {44'd0, s.adc_pressure};
            num = ((p <<< 31) - v2) * 64'sd3125;
            an  = num[63] ? -num : num;
            ad  = v1[63] ? -v1 : v1;
            q   = an / ad;
            p   = (num[63] != v1[63]) ? -q : q;
            ps  = p >>> 13;
            w1  = (p9 * ps * ps) >>> 25;
            w2  = (p8 * p) >>> 19;
            p   = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            r.pressure_pa  = p[31:8];
            r.divisor_zero = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res_item exp_r;
        if (!i_rst_n) begin
            temp_cal_q  <= '0;
            press_a_q   <= '0;
            press_b_q   <= '0;
            press_p9_q  <= '0;
            fail_count  = 0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    RegTempCal: temp_cal_q <= i_pwdata[47:0];
                    RegPressA:  press_a_q  <= i_pwdata;
                    RegPressB:  press_b_q  <= i_pwdata;
                    RegPressP9: press_p9_q <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                expected_q.push_back(compensate(i_in));
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: unexpected transaction %p", i_res);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.temperature_centi !== i_res.temperature_centi
                            || exp_r.pressure_pa !== i_res.pressure_pa
                            || exp_r.divisor_zero !== i_res.divisor_zero) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("checker: mismatch temp %0d/%0d press %0d/%0d zero %0b/%0b",
                                exp_r.temperature_centi, i_res.temperature_centi,
                                exp_r.pressure_pa, i_res.pressure_pa,
                                exp_r.divisor_zero, i_res.divisor_zero);
                    end
                end
            end
        end
    end
endmodule

### verif/tb.sv
// Top of the compensation core testbench: clock, reset, calibration phases,
// sample stimulus, result draining, watchdog and verdict.
// Depends on ptc_pkg, pressure_temp_compensation_core and ptc_checker.
module tb;
    import ptc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 5000;
    localparam int Settle    = 150;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push  = 1'b0;
    logic        o_full;
    t_in_item    i_in    = '0;
    logic        o_empty;
    logic        i_pop   = 1'b0;
    t_res_item   o_res;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    always #10 i_clk = ~i_clk;

    pressure_temp_compensation_core dut (.*);

    ptc_checker chk (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_in, .i_empty(o_empty), .i_pop,
        .i_res(o_res), .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_pop <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)
                || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [47:0] tcal, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [63:0] p9);
        write_reg(RegTempCal, {16'($urandom), tcal});
        write_reg(RegPressA, pa);
        write_reg(RegPressB, pb);
        write_reg(RegPressP9, p9);
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic send(input logic [19:0] temp, input logic [19:0] press);
        while (!calm && $urandom_range(99) < 27) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_in   <= '{adc_temperature: temp, adc_pressure: press};
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic run_phase(input int count);
        send(20'd0, 20'd0);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'd0, 20'hFFFFF);
        send(20'hFFFFF, 20'd0);
        send(20'd519888, 20'd415148);
        send(20'h80000, 20'h7FFFF);
        repeat (count) begin
            if ($urandom_range(9) < 7)
                send(20'($urandom_range(600000, 400000)),
                     20'($urandom_range(700000, 200000)));
            else
                send(20'($urandom), 20'($urandom));
        end
        i_push <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(61);
        drain();
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
                 {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 64'd6000);
        run_phase(61);
        drain();
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, -16'sd10685, 16'd0},
                 {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 64'd6000);
        run_phase(61);
        drain();
        load_cal('1, '1, '1, '1);
        run_phase(61);
        drain();
        load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, 64'h8000_7FFF_8000_FFFF,
                 64'h7FFF_8000_7FFF_8000, 64'hFFFF_FFFF_FFFF_8000);
        run_phase(61);
        drain();
        load_cal({16'h7FFF, 16'h8000, 16'h0000}, 64'h7FFF_8000_7FFF_0001,
                 64'h8000_7FFF_8000_7FFF, 64'h7FFF);
        run_phase(61);
        repeat (3) begin
            drain();
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            run_phase(61);
        end
        drain();
        calm = 1'b1;
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
                 {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 64'd6000);
        run_phase(40);
        calm = 1'b0;
        drain();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_front.sv
hw/rtl/ptc_fifo.sv
hw/rtl/ptc_back.sv
hw/rtl/pressure_temp_compensation_core.sv
verif/ptc_checker.sv
verif/tb.sv
